// ----- rtl/callout_label_placer_unit_assert.svh -----
// assertion macros for the callout label placer unit
`ifndef CALLOUT_LABEL_PLACER_UNIT_ASSERT_SVH
`define CALLOUT_LABEL_PLACER_UNIT_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define CLP_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define CLP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/clp_pkg.sv -----
// ----------------------------------------------------------------------------
// clp_pkg
// types and constants shared by the callout label placer
// ----------------------------------------------------------------------------
package clp_pkg;

    localparam int COORD_FRAC_BITS = 4;
    localparam logic signed [26:0] COORD_LIMIT = 27'sd65536 <<< COORD_FRAC_BITS;

    localparam int CW = 22;     // coordinate width
    localparam int SW = 21;     // size width
    localparam int QB = 24;     // quotient bits of the attach divider
    localparam int RW = 52;     // divider remainder width
    localparam int MW = 27;     // divider divisor width
    localparam logic signed [24:0] Q_BIAS = 25'sd8388608;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_TOP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_SPAN_X = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_SPAN_Y = 2'd3;

    localparam logic [SW-1:0] SPAN_X_RESET = 21'd30720;
    localparam logic [SW-1:0] SPAN_Y_RESET = 21'd17280;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic [SW-1:0]        t_size;
    typedef logic signed [24:0]   t_pos;
    typedef logic signed [26:0]   t_dbl;
    typedef logic signed [53:0]   t_prod;
    typedef logic signed [55:0]   t_num;

    typedef enum logic [1:0] {
        ST_PLACED  = 2'd0,
        ST_HIDDEN  = 2'd1,
        ST_NOFIT   = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef struct packed {
        t_coord left;
        t_coord top;
        t_size  span_x;
        t_size  span_y;
    } t_area;

    // classified and placed callout, front to back
    typedef struct packed {
        t_status status;
        t_coord  anchor_x;
        t_coord  anchor_y;
        t_pos    label_x;
        t_pos    label_y;
        t_size   width;
        t_size   height;
    } t_placed;

endpackage

// ----- rtl/clp_if.sv -----
// ----------------------------------------------------------------------------
// clp_item_if / clp_res_if
// valid/ready channels for callout items and placement results
// ----------------------------------------------------------------------------
interface clp_item_if;
    logic            valid;
    logic            ready;
    clp_pkg::t_coord anchor_x;
    clp_pkg::t_coord anchor_y;
    clp_pkg::t_coord offset_x;
    clp_pkg::t_coord offset_y;
    clp_pkg::t_size  label_width;
    clp_pkg::t_size  label_height;
    clp_pkg::t_size  margin;
    logic            visible;

    modport source (output valid, anchor_x, anchor_y, offset_x, offset_y, label_width,
                    label_height, margin, visible, input ready);
    modport sink (input valid, anchor_x, anchor_y, offset_x, offset_y, label_width,
                  label_height, margin, visible, output ready);
endinterface

interface clp_res_if;
    logic             valid;
    logic             ready;
    clp_pkg::t_status status;
    clp_pkg::t_coord  label_x;
    clp_pkg::t_coord  label_y;
    clp_pkg::t_coord  attach_x;
    clp_pkg::t_coord  attach_y;

    modport source (output valid, status, label_x, label_y, attach_x, attach_y, input ready);
    modport sink (input valid, status, label_x, label_y, attach_x, attach_y, output ready);
endinterface

// ----- rtl/clp_front.sv -----
// ----------------------------------------------------------------------------
// clp_front
// accepts callouts, classifies them and places the label on both axes
// ----------------------------------------------------------------------------
module clp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    clp_item_if.sink         i_item,
    input  clp_pkg::t_area   i_area,
    output logic             o_push,
    output clp_pkg::t_placed o_entry,
    input  logic             i_full
);

    typedef struct packed {
        clp_pkg::t_pos p0;
        clp_pkg::t_pos p1;
        clp_pkg::t_pos p2;
        clp_pkg::t_pos lo;
        clp_pkg::t_pos hi;
        logic          flip;
    } t_cand;

    function automatic t_cand cand_calc(input clp_pkg::t_pos anc, input clp_pkg::t_pos off,
                                        input clp_pkg::t_pos size, input clp_pkg::t_pos start,
                                        input clp_pkg::t_pos span, input clp_pkg::t_pos mar);
        t_cand         c;
        clp_pkg::t_pos aoff;
        clp_pkg::t_pos far;
        aoff   = (off < 0) ? -off : off;
        far    = start + span - mar;
        c.p0   = anc + off;
        c.p1   = anc - aoff - size;
        c.p2   = anc + aoff;
        c.lo   = start + mar;
        c.hi   = far - size;
        c.flip = (anc + off + size) > far;
        return c;
    endfunction

    function automatic clp_pkg::t_pos place_sel(input t_cand c);
        logic          lt0, lt1, lt2, gt0, gt1, gt2, lo_gt_hi;
        logic          b_lt, b_gt;
        clp_pkg::t_pos pb;
        clp_pkg::t_pos res;
        lt0 = c.p0 < c.lo;
        lt1 = c.p1 < c.lo;
        lt2 = c.p2 < c.lo;
        gt0 = c.p0 > c.hi;
        gt1 = c.p1 > c.hi;
        gt2 = c.p2 > c.hi;
        lo_gt_hi = c.lo > c.hi;
        // overflow flips, underflow pushes out by the offset magnitude
        if (c.flip ? lt1 : lt0) begin
            pb = c.p2; b_lt = lt2; b_gt = gt2;
        end else if (c.flip) begin
            pb = c.p1; b_lt = lt1; b_gt = gt1;
        end else begin
            pb = c.p0; b_lt = lt0; b_gt = gt0;
        end
        if (b_lt) begin
            res = lo_gt_hi ? c.hi : c.lo;
        end else if (b_gt) begin
            res = c.hi;
        end else begin
            res = pb;
        end
        return res;
    endfunction

    function automatic logic bad_s(input clp_pkg::t_coord v);
        return (clp_pkg::t_dbl'(v) > clp_pkg::COORD_LIMIT) ||
               (clp_pkg::t_dbl'(v) < -clp_pkg::COORD_LIMIT);
    endfunction

    function automatic logic bad_u(input clp_pkg::t_size v);
        return clp_pkg::t_dbl'(v) > clp_pkg::COORD_LIMIT;
    endfunction

    // stage 1: classification and placement candidates
    logic             r_f1_v;
    clp_pkg::t_status r_f1_status;
    clp_pkg::t_coord  r_f1_ax, r_f1_ay;
    clp_pkg::t_size   r_f1_w, r_f1_h;
    t_cand            r_f1_cx, r_f1_cy;
    // stage 2: placed entry
    logic             r_f2_v;
    clp_pkg::t_placed r_f2;

    clp_pkg::t_status n_status;
    t_cand            n_cx, n_cy;
    logic             w_f1_ready, w_f2_ready, w_take, w_f1_adv;
    logic             w_inv, w_hid, w_nofit;
    clp_pkg::t_pos    w_ax, w_ay, w_left, w_top, w_sx, w_sy, w_w, w_h, w_mar;

    assign w_f2_ready   = !r_f2_v || !i_full;
    assign w_f1_ready   = !r_f1_v || w_f2_ready;
    assign i_item.ready = w_f1_ready;
    assign w_take       = i_item.valid && w_f1_ready;
    assign w_f1_adv     = r_f1_v && w_f2_ready;
    assign o_push       = r_f2_v && !i_full;
    assign o_entry      = r_f2;

    always_comb begin
        w_ax   = clp_pkg::t_pos'(i_item.anchor_x);
        w_ay   = clp_pkg::t_pos'(i_item.anchor_y);
        w_left = clp_pkg::t_pos'(i_area.left);
        w_top  = clp_pkg::t_pos'(i_area.top);
        w_sx   = clp_pkg::t_pos'(i_area.span_x);
        w_sy   = clp_pkg::t_pos'(i_area.span_y);
        w_w    = clp_pkg::t_pos'(i_item.label_width);
        w_h    = clp_pkg::t_pos'(i_item.label_height);
        w_mar  = clp_pkg::t_pos'(i_item.margin);

        w_inv = bad_s(i_item.anchor_x) || bad_s(i_item.anchor_y) ||
                bad_s(i_item.offset_x) || bad_s(i_item.offset_y) ||
                bad_s(i_area.left) || bad_s(i_area.top) ||
                bad_u(i_item.label_width) || bad_u(i_item.label_height) ||
                bad_u(i_item.margin) || bad_u(i_area.span_x) || bad_u(i_area.span_y) ||
                (i_item.label_width == '0) || (i_item.label_height == '0);
        w_hid = !i_item.visible || (w_ax < w_left) || (w_ax >= w_left + w_sx) ||
                (w_ay < w_top) || (w_ay >= w_top + w_sy);
        w_nofit = (w_w + (w_mar <<< 1) > w_sx) || (w_h + (w_mar <<< 1) > w_sy);

        priority if (w_inv) begin
            n_status = clp_pkg::ST_INVALID;
        end else if (w_hid) begin
            n_status = clp_pkg::ST_HIDDEN;
        end else if (w_nofit) begin
            n_status = clp_pkg::ST_NOFIT;
        end else begin
            n_status = clp_pkg::ST_PLACED;
        end

        n_cx = cand_calc(w_ax, clp_pkg::t_pos'(i_item.offset_x), w_w, w_left, w_sx, w_mar);
        n_cy = cand_calc(w_ay, clp_pkg::t_pos'(i_item.offset_y), w_h, w_top, w_sy, w_mar);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else begin
            if (w_f1_ready) r_f1_v <= i_item.valid;
            if (w_f2_ready) r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_f1_status <= n_status;
            r_f1_ax     <= i_item.anchor_x;
            r_f1_ay     <= i_item.anchor_y;
            r_f1_w      <= i_item.label_width;
            r_f1_h      <= i_item.label_height;
            r_f1_cx     <= n_cx;
            r_f1_cy     <= n_cy;
        end
        if (w_f1_adv) begin
            r_f2.status   <= r_f1_status;
            r_f2.anchor_x <= r_f1_ax;
            r_f2.anchor_y <= r_f1_ay;
            r_f2.label_x  <= place_sel(r_f1_cx);
            r_f2.label_y  <= place_sel(r_f1_cy);
            r_f2.width    <= r_f1_w;
            r_f2.height   <= r_f1_h;
        end
    end

endmodule

// ----- rtl/clp_queue.sv -----
// ----------------------------------------------------------------------------
// clp_queue
// small fifo of placed callouts between front and back
// ----------------------------------------------------------------------------
module clp_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  clp_pkg::t_placed i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output clp_pkg::t_placed o_head,
    output logic             o_empty
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    clp_pkg::t_placed r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CNTW-1:0]  r_cnt;
    logic             w_push_ok, w_pop_ok;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full    = (r_cnt == CNTW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_push_ok = i_push && !o_full;
    assign w_pop_ok  = i_pop && !o_empty;
    assign o_head    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push_ok) r_wr <= ptr_inc(r_wr);
            if (w_pop_ok)  r_rd <= ptr_inc(r_rd);
            if (w_push_ok && !w_pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop_ok && !w_push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) r_mem[r_wr] <= i_entry;
    end

endmodule

// ----- rtl/clp_back.sv -----
// ----------------------------------------------------------------------------
// clp_back
// leader attachment point: products, branch choice, pipelined divider
// ----------------------------------------------------------------------------
module clp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  clp_pkg::t_placed i_head,
    input  logic             i_empty,
    output logic             o_pop,
    clp_res_if.source        o_res
);

    localparam int QB = clp_pkg::QB;
    localparam int RW = clp_pkg::RW;
    localparam int MW = clp_pkg::MW;

    typedef struct packed {
        clp_pkg::t_status status;
        clp_pkg::t_pos    lx;
        clp_pkg::t_pos    ly;
    } t_base;

    typedef struct packed {
        t_base         b;
        clp_pkg::t_pos lxw;
        clp_pkg::t_pos lyh;
        clp_pkg::t_dbl w;
        clp_pkg::t_dbl h;
        clp_pkg::t_dbl cx2;
        clp_pkg::t_dbl cy2;
        clp_pkg::t_dbl dx2;
        clp_pkg::t_dbl dy2;
    } t_s1;

    typedef struct packed {
        t_base          b;
        clp_pkg::t_pos  lxw;
        clp_pkg::t_pos  lyh;
        clp_pkg::t_dbl  cy2;
        clp_pkg::t_dbl  adx;
        clp_pkg::t_dbl  ady;
        logic           sx, sy, zx, zy;
        clp_pkg::t_prod pc, pd, pe, pf;
    } t_s2;

    typedef struct packed {
        t_base          b;
        clp_pkg::t_pos  lxw;
        clp_pkg::t_pos  lyh;
        clp_pkg::t_dbl  cy2;
        clp_pkg::t_dbl  adx;
        clp_pkg::t_dbl  ady;
        logic           sx, sy, zx, zy;
        clp_pkg::t_prod nc, ne, pd, pf, mag_d, mag_f;
    } t_s3;

    typedef struct packed {
        t_base         b;
        clp_pkg::t_num num;
        clp_pkg::t_dbl d;
        clp_pkg::t_dbl cy2;
        clp_pkg::t_pos side;
        logic          qy;
        logic          zero;
    } t_s4;

    typedef struct packed {
        t_base          b;
        clp_pkg::t_pos  side;
        logic           qy;
        logic [RW-1:0]  r;
        logic [MW-1:0]  m;
        logic [QB-1:0]  q;
    } t_ds;

    logic                 w_en;
    logic                 r_v1, r_v2, r_v3, r_v4;
    logic [QB:0]          r_dv;
    t_s1                  r_s1, n_s1;
    t_s2                  r_s2, n_s2;
    t_s3                  r_s3, n_s3;
    t_s4                  r_s4, n_s4;
    t_ds                  r_ds [QB+1];
    t_ds                  n_ds [QB+1];
    logic                 r_o_v;
    clp_pkg::t_status     r_o_status;
    clp_pkg::t_coord      r_o_lx, r_o_ly, r_o_tx, r_o_ty;
    clp_pkg::t_coord      w_lx, w_ly, w_tq, w_side;
    logic signed [24:0]   w_qs;
    clp_pkg::t_num        w_numx, w_numy;
    logic                 w_xbr;

    function automatic clp_pkg::t_coord sat22(input logic signed [25:0] v);
        clp_pkg::t_coord res;
        if (v > 26'sd2097151) begin
            res = 22'sh1FFFFF;
        end else if (v < -26'sd2097152) begin
            res = 22'sh200000;
        end else begin
            res = v[clp_pkg::CW-1:0];
        end
        return res;
    endfunction

    assign w_en  = !r_o_v || o_res.ready;
    assign o_pop = w_en && !i_empty;

    always_comb begin
        // doubled center and center-to-anchor vector
        n_s1.b.status = i_head.status;
        n_s1.b.lx     = i_head.label_x;
        n_s1.b.ly     = i_head.label_y;
        n_s1.lxw      = i_head.label_x + clp_pkg::t_pos'(i_head.width);
        n_s1.lyh      = i_head.label_y + clp_pkg::t_pos'(i_head.height);
        n_s1.w        = clp_pkg::t_dbl'(i_head.width);
        n_s1.h        = clp_pkg::t_dbl'(i_head.height);
        n_s1.cx2      = (clp_pkg::t_dbl'(i_head.label_x) <<< 1) + clp_pkg::t_dbl'(i_head.width);
        n_s1.cy2      = (clp_pkg::t_dbl'(i_head.label_y) <<< 1) + clp_pkg::t_dbl'(i_head.height);
        n_s1.dx2      = (clp_pkg::t_dbl'(i_head.anchor_x) <<< 1)
                        - (clp_pkg::t_dbl'(i_head.label_x) <<< 1)
                        - clp_pkg::t_dbl'(i_head.width);
        n_s1.dy2      = (clp_pkg::t_dbl'(i_head.anchor_y) <<< 1)
                        - (clp_pkg::t_dbl'(i_head.label_y) <<< 1)
                        - clp_pkg::t_dbl'(i_head.height);

        // products
        n_s2.b   = r_s1.b;
        n_s2.lxw = r_s1.lxw;
        n_s2.lyh = r_s1.lyh;
        n_s2.cy2 = r_s1.cy2;
        n_s2.sx  = r_s1.dx2 < 0;
        n_s2.sy  = r_s1.dy2 < 0;
        n_s2.zx  = r_s1.dx2 == '0;
        n_s2.zy  = r_s1.dy2 == '0;
        n_s2.adx = (r_s1.dx2 < 0) ? -r_s1.dx2 : r_s1.dx2;
        n_s2.ady = (r_s1.dy2 < 0) ? -r_s1.dy2 : r_s1.dy2;
        n_s2.pc  = r_s1.cy2 * r_s1.dx2;
        n_s2.pd  = r_s1.dy2 * r_s1.w;
        n_s2.pe  = r_s1.cx2 * r_s1.dy2;
        n_s2.pf  = r_s1.dx2 * r_s1.h;

        // magnitudes and sign-corrected terms
        n_s3.b     = r_s2.b;
        n_s3.lxw   = r_s2.lxw;
        n_s3.lyh   = r_s2.lyh;
        n_s3.cy2   = r_s2.cy2;
        n_s3.adx   = r_s2.adx;
        n_s3.ady   = r_s2.ady;
        n_s3.sx    = r_s2.sx;
        n_s3.sy    = r_s2.sy;
        n_s3.zx    = r_s2.zx;
        n_s3.zy    = r_s2.zy;
        n_s3.nc    = r_s2.sx ? -r_s2.pc : r_s2.pc;
        n_s3.ne    = r_s2.sy ? -r_s2.pe : r_s2.pe;
        n_s3.pd    = r_s2.pd;
        n_s3.pf    = r_s2.pf;
        n_s3.mag_d = (r_s2.pd < 0) ? -r_s2.pd : r_s2.pd;
        n_s3.mag_f = (r_s2.pf < 0) ? -r_s2.pf : r_s2.pf;

        // pick the border that the leader crosses
        w_xbr  = r_s3.mag_f >= r_s3.mag_d;
        w_numx = clp_pkg::t_num'(r_s3.nc) + clp_pkg::t_num'(r_s3.pd);
        w_numy = clp_pkg::t_num'(r_s3.ne) + clp_pkg::t_num'(r_s3.pf);
        n_s4.b    = r_s3.b;
        n_s4.cy2  = r_s3.cy2;
        n_s4.qy   = w_xbr;
        n_s4.zero = r_s3.zx && r_s3.zy;
        n_s4.num  = w_xbr ? w_numx : w_numy;
        n_s4.d    = w_xbr ? r_s3.adx : r_s3.ady;
        if (w_xbr) begin
            n_s4.side = (!r_s3.sx && !r_s3.zx) ? r_s3.lxw : r_s3.b.lx;
        end else begin
            n_s4.side = (!r_s3.sy && !r_s3.zy) ? r_s3.lyh : r_s3.b.ly;
        end

        // divider load: biased numerator so the quotient is unsigned
        n_ds[0].b    = r_s4.b;
        n_ds[0].side = r_s4.side;
        n_ds[0].qy   = r_s4.qy;
        n_ds[0].q    = '0;
        if (r_s4.zero) begin
            n_ds[0].r = RW'((clp_pkg::t_num'(r_s4.cy2) <<< 1) + clp_pkg::t_num'(2)
                            + (clp_pkg::t_num'(4) <<< (QB - 1)));
            n_ds[0].m = MW'(4);
        end else begin
            n_ds[0].r = RW'((r_s4.num <<< 1) + (clp_pkg::t_num'(r_s4.d) <<< 1)
                            + (clp_pkg::t_num'(r_s4.d) <<< (QB + 1)));
            n_ds[0].m = MW'(r_s4.d) << 2;
        end

        // one quotient bit per stage
        for (int k = 0; k < QB; k++) begin
            n_ds[k+1] = r_ds[k];
            if (r_ds[k].r >= (RW'(r_ds[k].m) << (QB - 1 - k))) begin
                n_ds[k+1].r = r_ds[k].r - (RW'(r_ds[k].m) << (QB - 1 - k));
                n_ds[k+1].q[QB-1-k] = 1'b1;
            end
        end

        // unbias, saturate, route quotient to its axis
        w_qs   = $signed({1'b0, r_ds[QB].q}) - clp_pkg::Q_BIAS;
        w_tq   = sat22(26'(w_qs));
        w_side = sat22(26'(r_ds[QB].side));
        w_lx   = sat22(26'(r_ds[QB].b.lx));
        w_ly   = sat22(26'(r_ds[QB].b.ly));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_dv  <= '0;
            r_o_v <= 1'b0;
        end else if (w_en) begin
            r_v1  <= !i_empty;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_v4  <= r_v3;
            r_dv  <= {r_dv[QB-1:0], r_v4};
            r_o_v <= r_dv[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
            for (int k = 0; k <= QB; k++) begin
                r_ds[k] <= n_ds[k];
            end
            r_o_status <= r_ds[QB].b.status;
            if (r_ds[QB].b.status == clp_pkg::ST_PLACED) begin
                r_o_lx <= w_lx;
                r_o_ly <= w_ly;
                r_o_tx <= r_ds[QB].qy ? w_side : w_tq;
                r_o_ty <= r_ds[QB].qy ? w_tq : w_side;
            end else begin
                r_o_lx <= '0;
                r_o_ly <= '0;
                r_o_tx <= '0;
                r_o_ty <= '0;
            end
        end
    end

    assign o_res.valid    = r_o_v;
    assign o_res.status   = r_o_status;
    assign o_res.label_x  = r_o_lx;
    assign o_res.label_y  = r_o_ly;
    assign o_res.attach_x = r_o_tx;
    assign o_res.attach_y = r_o_ty;

endmodule

// ----- rtl/callout_label_placer_unit.sv -----
// ----------------------------------------------------------------------------
// callout_label_placer_unit
// places one callout label per item inside the configured area
// ----------------------------------------------------------------------------
// throughput: one item per cycle while the result port is not stalled, set by
//   the fully pipelined attach divider (24 stages, one quotient bit each)
//   behind the front placement stages
// reset: synchronous active-low i_rst_n clears all valid bits and the queue,
//   area registers return to left 0, top 0, spans 30720 x 17280
module callout_label_placer_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    clp_item_if.sink                        i_item,
    clp_res_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [clp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [clp_pkg::CW-1:0]          i_cfg_data
);

    `include "callout_label_placer_unit_assert.svh"

    // placement area registers
    clp_pkg::t_area   r_area;

    // front to queue, queue to back
    logic             w_push, w_full, w_pop, w_empty;
    clp_pkg::t_placed w_entry, w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area.left   <= '0;
            r_area.top    <= '0;
            r_area.span_x <= clp_pkg::SPAN_X_RESET;
            r_area.span_y <= clp_pkg::SPAN_Y_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                clp_pkg::REG_AREA_LEFT:   r_area.left   <= i_cfg_data;
                clp_pkg::REG_AREA_TOP:    r_area.top    <= i_cfg_data;
                clp_pkg::REG_AREA_SPAN_X: r_area.span_x <= i_cfg_data[clp_pkg::SW-1:0];
                clp_pkg::REG_AREA_SPAN_Y: r_area.span_y <= i_cfg_data[clp_pkg::SW-1:0];
                default:                  r_area.left   <= r_area.left;
            endcase
        end
    end

    // front: range checks, visibility, fit, flip/push/clamp per axis
    clp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_area  (r_area),
        .o_push  (w_push),
        .o_entry (w_entry),
        .i_full  (w_full)
    );

    // queue lets the front keep taking items while the back is stalled, until it is full
    clp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty)
    );

    // back: leader crossing point through products and the divider pipe
    clp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

    // a result that is not placed carries no coordinates
    `CLP_ASSERT_IMPLY(a_unplaced_zero,
        o_res.valid && (o_res.status != clp_pkg::ST_PLACED),
        (o_res.label_x == '0) && (o_res.label_y == '0) &&
        (o_res.attach_x == '0) && (o_res.attach_y == '0),
        "unplaced result with nonzero coordinates")

    // a placed label never starts left of or above the area
    `CLP_ASSERT_IMPLY(a_placed_in_area,
        o_res.valid && (o_res.status == clp_pkg::ST_PLACED),
        (o_res.label_x >= r_area.left) && (o_res.label_y >= r_area.top),
        "placed label outside area")

    // an item pushed into the queue is there on the next cycle
    `CLP_ASSERT_NEXT(a_push_lands, w_push, !w_empty, "queue push lost")

endmodule

// ----- tb/sv/clp_placement_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_placement_checker
// watches the item, result and register ports, predicts every placement
// and compares each result field by field with the oldest prediction
// ----------------------------------------------------------------------------
module clp_placement_checker
    import clp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    clp_item_if                  i_item,
    clp_res_if                   i_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CW-1:0]        i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_placed
);

    localparam longint LIMIT = 64'sd65536 <<< COORD_FRAC_BITS;

    typedef struct packed {
        t_status status;
        t_coord  label_x;
        t_coord  label_y;
        t_coord  attach_x;
        t_coord  attach_y;
    } t_placement;

    t_coord     area_left;
    t_coord     area_top;
    t_size      area_span_x;
    t_size      area_span_y;
    t_placement placement_q[$];

    function automatic longint labs(longint v);
        return v < 0 ? -v : v;
    endfunction

    // nearest step, ties toward plus infinity
    function automatic longint round_near(longint n, longint d);
        longint nn;
        longint dd;
        longint q;
        nn = 2 * n + d;
        dd = 2 * d;
        q  = nn / dd;
        if (nn % dd != 0 && nn < 0)
            q--;
        return q;
    endfunction

    function automatic t_coord clamp22(longint v);
        if (v > 2097151)
            return t_coord'(2097151);
        if (v < -2097152)
            return t_coord'(-2097152);
        return t_coord'(v);
    endfunction

    function automatic longint axis_pos(longint anc, longint off, longint len,
                                        longint start, longint span, longint mar);
        longint lo;
        longint hi;
        longint pos;
        lo  = start + mar;
        hi  = start + span - mar - len;
        pos = anc + off;
        if (pos + len > start + span - mar)
            pos = anc - labs(off) - len;
        if (pos < lo)
            pos = anc + labs(off);
        if (pos < lo)
            pos = lo;
        if (pos > hi)
            pos = hi;
        return pos;
    endfunction

    function automatic t_placement predict_placement();
        t_placement r;
        longint ax, ay, ox, oy, w, h, mar, lf, tp, sx, sy;
        longint lx, ly, tx, ty, cx2, cy2, dx2, dy2, d;
        ax  = longint'(i_item.anchor_x);
        ay  = longint'(i_item.anchor_y);
        ox  = longint'(i_item.offset_x);
        oy  = longint'(i_item.offset_y);
        w   = longint'({1'b0, i_item.label_width});
        h   = longint'({1'b0, i_item.label_height});
        mar = longint'({1'b0, i_item.margin});
        lf  = longint'(area_left);
        tp  = longint'(area_top);
        sx  = longint'({1'b0, area_span_x});
        sy  = longint'({1'b0, area_span_y});
        r   = '0;
        if (labs(ax) > LIMIT || labs(ay) > LIMIT || labs(ox) > LIMIT || labs(oy) > LIMIT
            || labs(lf) > LIMIT || labs(tp) > LIMIT || w > LIMIT || h > LIMIT
            || mar > LIMIT || sx > LIMIT || sy > LIMIT || w == 0 || h == 0) begin
            r.status = ST_INVALID;
        end else if (!i_item.visible || ax < lf || ax >= lf + sx
                     || ay < tp || ay >= tp + sy) begin
            r.status = ST_HIDDEN;
        end else if (w + 2 * mar > sx || h + 2 * mar > sy) begin
            r.status = ST_NOFIT;
        end else begin
            r.status = ST_PLACED;
            lx  = axis_pos(ax, ox, w, lf, sx, mar);
            ly  = axis_pos(ay, oy, h, tp, sy, mar);
            cx2 = 2 * lx + w;
            cy2 = 2 * ly + h;
            dx2 = 2 * ax - cx2;
            dy2 = 2 * ay - cy2;
            if (dx2 == 0 && dy2 == 0) begin
                // anchor on the label center: left edge, vertical middle
                tx = lx;
                ty = round_near(cy2, 2);
            end else if (labs(dx2) * h >= labs(dy2) * w) begin
                d  = labs(dx2);
                tx = dx2 > 0 ? lx + w : lx;
                ty = round_near(cy2 * d + dy2 * w, 2 * d);
            end else begin
                d  = labs(dy2);
                ty = dy2 > 0 ? ly + h : ly;
                tx = round_near(cx2 * d + dx2 * h, 2 * d);
            end
            r.label_x  = clamp22(lx);
            r.label_y  = clamp22(ly);
            r.attach_x = clamp22(tx);
            r.attach_y = clamp22(ty);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_placement got;
        t_placement want;
        if (!i_rst_n) begin
            area_left   <= '0;
            area_top    <= '0;
            area_span_x <= SPAN_X_RESET;
            area_span_y <= SPAN_Y_RESET;
            placement_q.delete();
        end else begin
            if (i_item.valid && i_item.ready)
                placement_q.push_back(predict_placement());
            if (i_res.valid && i_res.ready) begin
                got = '{i_res.status, i_res.label_x, i_res.label_y,
                        i_res.attach_x, i_res.attach_y};
                o_checked++;
                if (placement_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: result with no item pending: %p", $time, got);
                end else begin
                    want = placement_q.pop_front();
                    if (want.status == ST_PLACED)
                        o_placed++;
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: mismatch expected %p actual %p", $time, want, got);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_AREA_LEFT:   area_left   <= t_coord'(i_cfg_data);
                    REG_AREA_TOP:    area_top    <= t_coord'(i_cfg_data);
                    REG_AREA_SPAN_X: area_span_x <= i_cfg_data[SW-1:0];
                    REG_AREA_SPAN_Y: area_span_y <= i_cfg_data[SW-1:0];
                    default: ;
                endcase
            end
        end
        o_pending <= placement_q.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_placed     = 0;
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// callout label placer: directed corner callouts, then random callouts over
// several area settings, with random gaps on both channels
// ----------------------------------------------------------------------------
module testbench;
    import clp_pkg::*;

    typedef struct {
        t_coord ax;
        t_coord ay;
        t_coord ox;
        t_coord oy;
        t_size  w;
        t_size  h;
        t_size  mar;
        logic   vis;
    } t_callout;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CW-1:0]        i_cfg_data;
    int                   fail_count;
    int                   pending;
    int                   checked;
    int                   placed;
    int                   sent;
    bit                   calm;       // no gaps on either side while set

    // testbench copy of the area, used to aim the random callouts
    longint area_l, area_t, area_sx, area_sy;

    clp_item_if item_bus ();
    clp_res_if  res_bus ();

    callout_label_placer_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_bus.sink),
        .o_res      (res_bus.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    clp_placement_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_bus),
        .i_res        (res_bus),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_placed     (placed)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // result side stalls, changed on the falling edge
    initial begin
        res_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_bus.ready = calm || ($urandom_range(99) >= 38);
        end
    end

    // generous fixed limit
    initial begin
        #(12 * 400000);
        $display("FAILED: results differ");
        $finish;
    end

    // hand one item over; called and left at a falling edge
    task automatic drive_callout(t_callout c);
        while (!calm && $urandom_range(99) < 38) begin
            item_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        item_bus.anchor_x     = c.ax;
        item_bus.anchor_y     = c.ay;
        item_bus.offset_x     = c.ox;
        item_bus.offset_y     = c.oy;
        item_bus.label_width  = c.w;
        item_bus.label_height = c.h;
        item_bus.margin       = c.mar;
        item_bus.visible      = c.vis;
        item_bus.valid        = 1'b1;
        do @(posedge i_clk); while (!item_bus.ready);
        sent++;
        @(negedge i_clk);
    endtask

    // wait for every result, then let the pipeline run dry
    task automatic drain();
        item_bus.valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_area(longint lf, longint tp, longint sx, longint sy);
        logic [CFG_IDX_W-1:0] idx [4];
        longint               val [4];
        idx = '{REG_AREA_LEFT, REG_AREA_TOP, REG_AREA_SPAN_X, REG_AREA_SPAN_Y};
        val = '{lf, tp, sx, sy};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we   = 1'b1;
            i_cfg_idx  = idx[i];
            i_cfg_data = val[i][CW-1:0];
            @(negedge i_clk);
        end
        i_cfg_we = 1'b0;
        area_l  = lf;
        area_t  = tp;
        area_sx = sx;
        area_sy = sy;
    endtask

    function automatic t_callout mk(longint ax, longint ay, longint ox, longint oy,
                                    longint w, longint h, longint mar, bit vis);
        t_callout c;
        c.ax = t_coord'(ax);
        c.ay = t_coord'(ay);
        c.ox = t_coord'(ox);
        c.oy = t_coord'(oy);
        c.w  = t_size'(w);
        c.h  = t_size'(h);
        c.mar = t_size'(mar);
        c.vis = vis;
        return c;
    endfunction

    function automatic longint pick(longint lo, longint hi);
        if (hi <= lo)
            return lo;
        return lo + longint'($urandom_range(32'(hi - lo)));
    endfunction

    // mostly a sensible callout inside the area, otherwise noise
    function automatic t_callout random_callout();
        t_callout c;
        longint   sx, sy, span_min;
        sx = area_sx > 1 ? area_sx : 1;
        sy = area_sy > 1 ? area_sy : 1;
        span_min = sx < sy ? sx : sy;
        if ($urandom_range(99) < 75) begin
            c = mk(pick(area_l, area_l + sx - 1), pick(area_t, area_t + sy - 1),
                   pick(-sx / 2, sx / 2), pick(-sy / 2, sy / 2),
                   pick(1, sx / 3 + 1), pick(1, sy / 3 + 1),
                   pick(0, span_min / 12), $urandom_range(19) != 0);
        end else begin
            c = mk(pick(-1048576, 1048576), pick(-1048576, 1048576),
                   pick(-1048576, 1048576), pick(-1048576, 1048576),
                   pick(0, 1048576), pick(0, 1048576), pick(0, 4096),
                   $urandom_range(1));
            // raw bit patterns, out of range values included
            if ($urandom_range(3) == 0) begin
                c.ax = t_coord'($urandom);
                c.oy = t_coord'($urandom);
                c.w  = t_size'($urandom);
                c.mar = t_size'($urandom);
            end
            if ($urandom_range(3) == 0) begin
                c.ay = t_coord'($urandom);
                c.ox = t_coord'($urandom);
                c.h  = t_size'($urandom);
            end
            if ($urandom_range(9) == 0)
                c.w = '0;
        end
        return c;
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) begin
            calm = (i >= count / 3 && i < count / 3 + count / 8);
            // sender holds off until the block is empty
            if (i == count / 2)
                drain();
            drive_callout(random_callout());
        end
        calm = 1'b0;
        drain();
    endtask

    initial begin
        item_bus.valid        = 1'b0;
        item_bus.anchor_x     = '0;
        item_bus.anchor_y     = '0;
        item_bus.offset_x     = '0;
        item_bus.offset_y     = '0;
        item_bus.label_width  = '0;
        item_bus.label_height = '0;
        item_bus.margin       = '0;
        item_bus.visible      = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_AREA_LEFT;
        i_cfg_data = '0;
        calm       = 1'b0;
        sent       = 0;
        area_l  = 0;
        area_t  = 0;
        area_sx = 30720;
        area_sy = 17280;
        i_rst_n = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed callouts against the reset area
        drive_callout(mk(1000, 1000, 40, 40, 320, 160, 16, 1));        // plain placement
        drive_callout(mk(30000, 500, 400, 100, 800, 200, 32, 1));      // flip on x
        drive_callout(mk(500, 17000, 100, 400, 200, 800, 32, 1));      // flip on y
        drive_callout(mk(50, 50, -400, -400, 200, 200, 16, 1));        // push back
        drive_callout(mk(100, 100, -5000, 9000, 30000, 16000, 100, 1)); // clamp
        drive_callout(mk(1000, 1000, -32, -16, 64, 32, 0, 1));         // anchor at center
        drive_callout(mk(1001, 999, -31, -17, 64, 32, 0, 1));          // rounding near center
        drive_callout(mk(1000, 1000, 10, 10, 0, 40, 0, 1));            // zero width
        drive_callout(mk(1000, 1000, 10, 10, 40, 0, 0, 1));            // zero height
        drive_callout(mk(1048577, 1000, 10, 10, 40, 40, 0, 1));        // anchor out of range
        drive_callout(mk(1000, -1048577, 10, 10, 40, 40, 0, 1));
        drive_callout(mk(1000, 1000, 1048577, -1048577, 40, 40, 0, 1));
        drive_callout(mk(1000, 1000, 10, 10, 1048577, 40, 0, 1));      // size out of range
        drive_callout(mk(1000, 1000, 10, 10, 40, 40, 2097151, 1));     // margin out of range
        drive_callout(mk(1000, 1000, 10, 10, 40, 40, 0, 0));           // hidden
        drive_callout(mk(30720, 1000, 10, 10, 40, 40, 0, 1));          // anchor at far edge
        drive_callout(mk(-1, 1000, 10, 10, 40, 40, 0, 1));             // anchor before edge
        drive_callout(mk(0, 17279, 10, 10, 40, 40, 0, 1));             // last row inside
        drive_callout(mk(1000, 1000, 10, 10, 30721, 40, 0, 1));        // no fit on x
        drive_callout(mk(1000, 1000, 10, 10, 40, 40, 8621, 1));        // no fit via margin
        drive_callout(mk(1000, 1000, 10, 10, 30720, 17280, 0, 1));     // exact fit
        drive_callout(mk(-1048576, 1048576, 1048576, -1048576, 1048576, 1048576,
                         1048576, 1));
        drain();
        random_phase(400);

        // whole coordinate space, edges of the saturation range
        write_area(-1048576, -1048576, 1048576, 1048576);
        drive_callout(mk(-1, -1, 1048576, 1048576, 1, 1, 0, 1));
        drive_callout(mk(-1048576, -1048576, -1048576, -1048576, 1048576, 1, 0, 1));
        random_phase(300);

        write_area(1048576, 1048576, 0, 0);                // empty area at the top end
        random_phase(60);
        write_area(-800, 320, 2000, 1200);
        random_phase(350);
        write_area(1048577, 0, 30720, 17280);              // left out of range
        random_phase(40);
        write_area(0, -1048577, 30720, 17280);             // top out of range
        random_phase(40);
        write_area(0, 0, 2097151, 1048577);                // spans out of range
        random_phase(40);
        write_area(4000, -3000, 30720, 17280);
        random_phase(350);
        write_area(-20, -20, 1, 1);                        // single step area
        random_phase(60);
        write_area(-900000, 500000, 1048576, 48);
        random_phase(200);

        drain();
        $display("%0d callouts sent over 10 area settings, %0d results checked, %0d placed",
                 sent, checked, placed);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d failures, %0d results missing", fail_count, pending);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/clp_pkg.sv
rtl/clp_if.sv
rtl/clp_front.sv
rtl/clp_queue.sv
rtl/clp_back.sv
rtl/callout_label_placer_unit.sv
tb/sv/clp_placement_checker.sv
tb/sv/testbench.sv
